// File: rtl/register_machine_execute_unit_core_macros.svh
// Assertion macros used by the checker file
`ifndef REGISTER_MACHINE_EXECUTE_UNIT_CORE_MACROS_SVH
`define REGISTER_MACHINE_EXECUTE_UNIT_CORE_MACROS_SVH

// same-cycle implication
`define RMEU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RMEU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rmeu_pkg.sv
// Package: types, codes and constants of the execute unit
`timescale 1ns / 1ps

package rmeu_pkg;

    localparam int MEM_WORDS   = 65536;
    localparam int STACK_START = 32768;
    localparam int MEM_AW      = $clog2(MEM_WORDS);
    localparam logic [3:0] PC_IDX = 4'd14;
    localparam logic [3:0] SP_IDX = 4'd15;
    localparam int IN_W  = 104;
    localparam int OUT_W = 152;

    typedef enum logic [4:0] {
        OP_RRMOV = 5'd0,  OP_IRMOV = 5'd1,  OP_RMMOV = 5'd2,  OP_MRMOV = 5'd3,
        OP_PUSH  = 5'd4,  OP_POP   = 5'd5,  OP_INC   = 5'd6,  OP_DEC   = 5'd7,
        OP_ADD   = 5'd8,  OP_SUB   = 5'd9,  OP_IMUL  = 5'd10, OP_DIV   = 5'd11,
        OP_NOT   = 5'd12, OP_XOR   = 5'd13, OP_OR    = 5'd14, OP_AND   = 5'd15,
        OP_SAL   = 5'd16, OP_SAR   = 5'd17, OP_CMP   = 5'd18, OP_JMP   = 5'd19,
        OP_JE    = 5'd20, OP_JNE   = 5'd21, OP_JLE   = 5'd22, OP_JL    = 5'd23,
        OP_JGE   = 5'd24, OP_JG    = 5'd25, OP_RECHO = 5'd26, OP_MECHO = 5'd27,
        OP_INPUT = 5'd28, OP_HLT   = 5'd29
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_RECHO   = 3'd1,
        ST_MECHO   = 3'd2,
        ST_HALT    = 3'd3,
        ST_DIVZERO = 3'd4,
        ST_ADDR    = 3'd5
    } t_status;

    typedef struct packed {
        logic load_in;
        logic read_regs;
        logic exec;
        logic mul_start;
        logic mul_step;
        logic div_start;
        logic div_step;
        logic wb;
        logic out_load;
        logic clr_step;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic is_mul;
        logic is_div;
        logic mul_last;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

// File: rtl/register_machine_execute_unit_core.sv
// Top level: execute unit of a 16-register, 64-bit register machine
`timescale 1ns / 1ps
// Usage:
//  s_axis carries one decoded instruction per transfer; m_axis returns one
//  result per instruction (status, echo index/value, next program counter).
//  Register 14 is the program counter, register 15 the stack register.
//  After reset a clearing pass zeroes all MEM_WORDS (65536) words of the data
//  memory, one word per cycle, with s_axis_tready low.
//  IMUL runs in four steps through a shared 32x32 multiplier; DIV runs
//  through a restoring divider, one quotient bit per cycle.
//  One instruction is worked on at a time; the next input is taken once the
//  result sits in the output register.
//  When the receiver stalls, the output register holds its result; the unit
//  finishes the next instruction and waits with it until the slot frees.
//  After HLT every instruction answers halted with an unchanged state.
module register_machine_execute_unit_core
    import rmeu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // operation[4:0], source_operand[35:5], dest_register[39:36], input_value[103:40]
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // status[2:0], echo_index[18:3], echo_value[82:19], next_pc[146:83], zero pad
    output logic [OUT_W-1:0] m_axis_tdata
);

    t_cmd cmd;
    t_sts sts;

    rmeu_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    rmeu_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_data (s_axis_tdata),
        .i_m_ready (m_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_m_data  (m_axis_tdata),
        .i_cmd     (cmd),
        .o_sts     (sts)
    );

endmodule

// File: rtl/rmeu_ctrl.sv
// Controller: sequences clear pass, register read, execute, multiply/divide steps, write-back, output
`timescale 1ns / 1ps

module rmeu_ctrl
    import rmeu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_valid,
    output logic o_s_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_MEM, S_WB, S_OUT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        o_cmd     = '0;
        o_s_ready = 1'b0;
        n_state   = r_state;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read_regs = 1'b1;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.is_mul) begin
                    o_cmd.mul_start = 1'b1;
                    n_state = S_MUL;
                end else if (i_sts.is_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_state = S_MEM;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_sts.mul_last) n_state = S_WB;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_WB;
            end
            S_MEM: n_state = S_WB;
            S_WB: begin
                o_cmd.wb = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/rmeu_dp.sv
// Datapath: register file, data memory, ALU, multiplier, divider, output register
`timescale 1ns / 1ps

module rmeu_dp
    import rmeu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IN_W-1:0]  i_in_data,
    input  logic             i_m_ready,
    output logic             o_m_valid,
    output logic [OUT_W-1:0] o_m_data,
    input  t_cmd             i_cmd,
    output t_sts             o_sts
);

    // latched item
    t_op         r_op;
    logic [30:0] r_imm;
    logic [3:0]  r_d;
    logic [63:0] r_in;

    // architectural state
    logic [63:0] rf_mem [16];
    logic [15:0] r_rf_vld;
    logic [63:0] r_pc, r_sp;
    logic [2:0]  r_flags;
    logic        r_halted;
    logic [63:0] mem [MEM_WORDS];

    logic [63:0] r_a_raw, r_b_raw, r_mrd;
    logic [MEM_AW-1:0] r_clr_addr;

    logic [63:0] r_prod, r_acc;
    logic [1:0]  r_mul_cnt;
    logic [63:0] r_q, r_rem;
    logic [5:0]  r_div_cnt;

    t_status     r_res_st;
    logic [15:0] r_res_idx;
    logic [63:0] r_res_val, r_res_pc;

    logic        r_out_vld;
    t_status     r_out_st;
    logic [15:0] r_out_idx;
    logic [63:0] r_out_val, r_out_pc;

    logic [3:0]  s_idx;
    logic [63:0] a, b, mem_addr, mem_wd, rf_val, sp_adj, pc_base, n_pc, n_sp, cmp_r;
    logic [31:0] mul_x, mul_y;
    logic [63:0] mul_p, div_w;
    logic [64:0] div_t;
    logic        addr_ok, rf_we, mem_we, advance, jmp, lt, n_halted;
    logic [3:0]  rf_idx;
    logic [2:0]  n_flags;
    t_status     st;
    logic [15:0] eidx;
    logic [63:0] eval;
    logic        wr_en;
    logic [MEM_AW-1:0] wr_addr;
    logic [63:0] wr_data;

    assign s_idx = r_imm[3:0];

    always_comb begin
        if (r_d == PC_IDX) a = r_pc;
        else if (r_d == SP_IDX) a = r_sp;
        else a = r_rf_vld[r_d] ? r_a_raw : 64'd0;
        if (s_idx == PC_IDX) b = r_pc;
        else if (s_idx == SP_IDX) b = r_sp;
        else b = r_rf_vld[s_idx] ? r_b_raw : 64'd0;
    end

    always_comb begin
        case (r_op)
            OP_RMMOV: mem_addr = a;
            OP_PUSH:  mem_addr = r_sp;
            OP_POP:   mem_addr = r_sp - 64'd1;
            default:  mem_addr = b;
        endcase
    end
    assign addr_ok = mem_addr < 64'(MEM_WORDS);

    assign lt = r_flags[1] ^ r_flags[2];
    assign cmp_r = a - b;

    // write-back decode
    always_comb begin
        rf_we    = 1'b0;
        rf_idx   = r_d;
        rf_val   = 64'd0;
        mem_we   = 1'b0;
        mem_wd   = b;
        sp_adj   = r_sp;
        st       = ST_OK;
        eidx     = 16'd0;
        eval     = 64'd0;
        advance  = 1'b1;
        jmp      = 1'b0;
        n_flags  = r_flags;
        n_halted = r_halted;
        if (r_halted) begin
            st      = ST_HALT;
            advance = 1'b0;
        end else begin
            case (r_op)
                OP_RRMOV: begin rf_we = 1'b1; rf_val = b; end
                OP_IRMOV: begin rf_we = 1'b1; rf_val = 64'(r_imm); end
                OP_RMMOV: begin
                    if (addr_ok) mem_we = 1'b1; else st = ST_ADDR;
                end
                OP_MRMOV: begin
                    if (addr_ok) begin rf_we = 1'b1; rf_val = r_mrd; end
                    else st = ST_ADDR;
                end
                OP_PUSH: begin
                    if (addr_ok) begin mem_we = 1'b1; sp_adj = r_sp + 64'd1; end
                    else st = ST_ADDR;
                end
                OP_POP: begin
                    if (addr_ok) begin
                        sp_adj = mem_addr;
                        rf_we  = 1'b1;
                        rf_idx = s_idx;
                        rf_val = r_mrd;
                    end else st = ST_ADDR;
                end
                OP_INC: begin rf_we = 1'b1; rf_idx = s_idx; rf_val = b + 64'd1; end
                OP_DEC: begin rf_we = 1'b1; rf_idx = s_idx; rf_val = b - 64'd1; end
                OP_ADD: begin rf_we = 1'b1; rf_val = a + b; end
                OP_SUB: begin rf_we = 1'b1; rf_val = a - b; end
                OP_IMUL: begin rf_we = 1'b1; rf_val = r_acc; end
                OP_DIV: begin
                    if (b == 64'd0) st = ST_DIVZERO;
                    else begin rf_we = 1'b1; rf_val = r_q; end
                end
                OP_NOT: begin rf_we = 1'b1; rf_idx = s_idx; rf_val = ~b; end
                OP_XOR: begin rf_we = 1'b1; rf_val = a ^ b; end
                OP_OR:  begin rf_we = 1'b1; rf_val = a | b; end
                OP_AND: begin rf_we = 1'b1; rf_val = a & b; end
                OP_SAL: begin
                    rf_we = 1'b1;
                    rf_val = (|r_imm[30:6]) ? 64'd0 : a << r_imm[5:0];
                end
                OP_SAR: begin
                    rf_we = 1'b1;
                    rf_val = (|r_imm[30:6]) ? 64'd0 : a >> r_imm[5:0];
                end
                OP_CMP: begin
                    n_flags[0] = (cmp_r == 64'd0);
                    n_flags[1] = cmp_r[63];
                    n_flags[2] = (a[63] ^ b[63]) & (a[63] ^ cmp_r[63]);
                end
                OP_JMP: jmp = 1'b1;
                OP_JE:  jmp = r_flags[0];
                OP_JNE: jmp = !r_flags[0];
                OP_JLE: jmp = lt | r_flags[0];
                OP_JL:  jmp = lt;
                OP_JGE: jmp = !lt;
                OP_JG:  jmp = !lt & !r_flags[0];
                OP_RECHO: begin st = ST_RECHO; eidx = 16'(s_idx); eval = b; end
                OP_MECHO: begin
                    if (addr_ok) begin st = ST_MECHO; eidx = b[15:0]; eval = r_mrd; end
                    else st = ST_ADDR;
                end
                OP_INPUT: begin
                    mem_wd = r_in;
                    if (addr_ok) mem_we = 1'b1; else st = ST_ADDR;
                end
                OP_HLT: begin st = ST_HALT; advance = 1'b0; n_halted = 1'b1; end
                default: ;
            endcase
        end
        if (jmp) advance = 1'b0;
        n_sp    = (rf_we && rf_idx == SP_IDX) ? rf_val : sp_adj;
        pc_base = (rf_we && rf_idx == PC_IDX) ? rf_val : r_pc;
        n_pc    = jmp ? b : (advance ? pc_base + 64'd1 : pc_base);
    end

    // multiplier operand select, 32x32 partial products
    always_comb begin
        case (r_mul_cnt)
            2'd0:    begin mul_x = a[31:0];  mul_y = b[31:0];  end
            2'd1:    begin mul_x = a[63:32]; mul_y = b[31:0];  end
            default: begin mul_x = a[31:0];  mul_y = b[63:32]; end
        endcase
    end
    assign mul_p = mul_x * mul_y;

    assign div_w = {r_rem[62:0], r_q[63]};
    assign div_t = {r_rem[63], div_w} - {1'b0, b};

    assign wr_en   = i_cmd.clr_step | (i_cmd.wb & mem_we);
    assign wr_addr = i_cmd.clr_step ? r_clr_addr : mem_addr[MEM_AW-1:0];
    assign wr_data = i_cmd.clr_step ? 64'd0 : mem_wd;

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (i_cmd.exec) r_mrd <= mem[mem_addr[MEM_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wb && !r_halted && rf_we && rf_idx != PC_IDX && rf_idx != SP_IDX)
            rf_mem[rf_idx] <= rf_val;
        if (i_cmd.read_regs) begin
            r_a_raw <= rf_mem[r_d];
            r_b_raw <= rf_mem[s_idx];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op  <= t_op'(i_in_data[4:0]);
            r_imm <= i_in_data[35:5];
            r_d   <= i_in_data[39:36];
            r_in  <= i_in_data[103:40];
        end
        if (i_cmd.mul_start) begin
            r_mul_cnt <= 2'd0;
            r_acc     <= 64'd0;
        end else if (i_cmd.mul_step) begin
            r_mul_cnt <= r_mul_cnt + 2'd1;
            r_prod    <= mul_p;
            if (r_mul_cnt == 2'd1) r_acc <= r_prod;
            else if (r_mul_cnt != 2'd0) r_acc <= r_acc + {r_prod[31:0], 32'd0};
        end
        if (i_cmd.div_start) begin
            r_q       <= a;
            r_rem     <= 64'd0;
            r_div_cnt <= 6'd0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + 6'd1;
            if (!div_t[64]) begin
                r_rem <= div_t[63:0];
                r_q   <= {r_q[62:0], 1'b1};
            end else begin
                r_rem <= div_w;
                r_q   <= {r_q[62:0], 1'b0};
            end
        end
        if (i_cmd.wb) begin
            r_res_st  <= st;
            r_res_idx <= eidx;
            r_res_val <= eval;
            r_res_pc  <= n_pc;
        end
        if (i_cmd.out_load) begin
            r_out_st  <= r_res_st;
            r_out_idx <= r_res_idx;
            r_out_val <= r_res_val;
            r_out_pc  <= r_res_pc;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld   <= '0;
            r_pc       <= 64'd0;
            r_sp       <= 64'(STACK_START);
            r_flags    <= 3'd0;
            r_halted   <= 1'b0;
            r_clr_addr <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.clr_step) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cmd.wb) begin
                if (!r_halted && rf_we) r_rf_vld[rf_idx] <= 1'b1;
                r_pc     <= n_pc;
                r_sp     <= n_sp;
                r_flags  <= n_flags;
                r_halted <= n_halted;
            end
            if (i_cmd.out_load) r_out_vld <= 1'b1;
            else if (i_m_ready) r_out_vld <= 1'b0;
        end
    end

    assign o_sts.clr_done = (r_clr_addr == MEM_AW'(MEM_WORDS - 1));
    assign o_sts.is_mul   = (r_op == OP_IMUL) && !r_halted;
    assign o_sts.is_div   = (r_op == OP_DIV) && !r_halted && (b != 64'd0);
    assign o_sts.mul_last = (r_mul_cnt == 2'd3);
    assign o_sts.div_last = (r_div_cnt == 6'd63);
    assign o_sts.out_free = !r_out_vld || i_m_ready;

    assign o_m_valid = r_out_vld;
    assign o_m_data  = {5'd0, r_out_pc, r_out_val, r_out_idx, r_out_st};

endmodule

// File: rtl/rmeu_checker.sv
// Port-level checker for the execute unit, bound to the top level
`timescale 1ns / 1ps
`include "register_machine_execute_unit_core_macros.svh"

module rmeu_checker
    import rmeu_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    logic echo;
    assign echo = (m_axis_tdata[2:0] == ST_RECHO) || (m_axis_tdata[2:0] == ST_MECHO);

    `RMEU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")
    `RMEU_ASSERT_NOW(a_status_range, m_axis_tvalid, m_axis_tdata[2:0] <= ST_ADDR, "status code out of range")
    `RMEU_ASSERT_NOW(a_echo_zero, m_axis_tvalid && !echo, m_axis_tdata[82:3] == 80'd0, "echo fields not zero")
    `RMEU_ASSERT_NEXT(a_busy_after_in, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready right after a transfer")

endmodule

bind register_machine_execute_unit_core rmeu_checker u_rmeu_checker (.*);
